>>> src/chk_pkg.sv
// Shared types and constants for the chained hash key set.
package chk_pkg;

   localparam int BUCKET_COUNT_DEFAULT = 1024;
   localparam int NODE_COUNT_DEFAULT   = 8192;

   localparam int KEY_W    = 31;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 3;

   localparam logic [MODE_W-1:0] MODE_LOOKUP     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_INSERT_NEW = 2'd2;

   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic load;
      logic clr_step;
      logic bkt_rd;
      logic node_rd_head;
      logic node_rd_next;
      logic insert;
   } dp_cmd_type;

   typedef struct packed {
      logic              clr_last;
      logic [MODE_W-1:0] mode;
      logic              bkt_valid;
      logic              key_match;
      logic              next_valid;
      logic              pool_full;
   } dp_sts_type;

endpackage

>>> src/chained_hash_key_set.sv
// Top level of the chained hash key set.
// Integer key set held as a hash table with separate chaining: bucket = key mod
// BUCKET_COUNT, new nodes pushed at the chain head from a bump-allocated pool of
// NODE_COUNT nodes. After reset a clearing pass through every bucket empties
// the bucket memory; req_stall stays high until it ends. One word is in work at
// a time: an insert (mode 1) runs through the hash, bucket check and response
// states; a lookup or conditional insert also walks any chain in the bucket, one
// node memory read per cycle. The modulo by reciprocal multiply runs in S_HASH1
// to S_HASH3, the last of which also reads the bucket memory; S_BCHK then checks
// the bucket entry. A finished word waits in the output register while the next
// word is accepted.
module chained_hash_key_set import chk_pkg::*; #(
   parameter int BUCKET_COUNT = BUCKET_COUNT_DEFAULT,
   parameter int NODE_COUNT   = NODE_COUNT_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [KEY_W-1:0]    req_key,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   chk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .cmd        (cmd),
      .sts        (sts)
   );

   chk_dp #(
      .BUCKET_COUNT (BUCKET_COUNT),
      .NODE_COUNT   (NODE_COUNT)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_mode (req_mode),
      .req_key  (req_key)
   );

endmodule

>>> src/chk_dp.sv
// Datapath: bucket hash, bucket and node memories, node allocator.
module chk_dp import chk_pkg::*; #(
   parameter int BUCKET_COUNT = BUCKET_COUNT_DEFAULT,
   parameter int NODE_COUNT   = NODE_COUNT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_sts_type        sts,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [KEY_W-1:0]  req_key
);

   localparam int BW  = $clog2(BUCKET_COUNT);
   localparam int NW  = $clog2(NODE_COUNT);
   localparam int UW  = $clog2(NODE_COUNT + 1);
   localparam int RSH = KEY_W + BW;
   localparam int PW  = 2 * KEY_W + 1;
   localparam logic [63:0]      RECIP_FULL = (64'd1 << RSH) / BUCKET_COUNT;
   localparam logic [PW-1:0]    RECIP      = PW'(RECIP_FULL[31:0]);
   localparam logic [KEY_W-1:0] BC_K       = KEY_W'(BUCKET_COUNT);
   localparam logic [BW-1:0]    BC_LAST    = BW'(BUCKET_COUNT - 1);
   localparam logic [UW-1:0]    NC_U       = UW'(NODE_COUNT);

   // bucket word: {valid, head}; node word: {next_valid, next, key}
   logic [NW:0]         bucket_mem [BUCKET_COUNT];
   logic [KEY_W+NW:0]   node_mem   [NODE_COUNT];

   logic [MODE_W-1:0]   mode_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [KEY_W-1:0]    q_ff;
   logic [KEY_W-1:0]    qb_ff;
   logic [BW-1:0]       bucket_ff;
   logic [BW-1:0]       clr_cnt_ff;
   logic [UW-1:0]       used_ff;
   logic [NW:0]         bkt_rd_ff;
   logic [KEY_W+NW:0]   node_rd_ff;

   logic [PW-1:0]       prod;
   logic [KEY_W-1:0]    rem;
   logic [KEY_W-1:0]    rem_fix;
   logic [BW-1:0]       bucket_in;
   logic [NW-1:0]       node_addr;
   logic [NW:0]         bkt_wdata;
   logic [BW-1:0]       bkt_waddr;

   // reciprocal estimate is at most one short, so one correction suffices
   assign prod      = PW'(key_ff) * RECIP;
   assign rem       = key_ff - qb_ff;
   assign rem_fix   = (rem >= BC_K) ? rem - BC_K : rem;
   assign bucket_in = rem_fix[BW-1:0];

   assign node_addr = cmd.node_rd_head ? bkt_rd_ff[NW-1:0] : node_rd_ff[KEY_W+NW-1:KEY_W];
   assign bkt_waddr = cmd.clr_step ? clr_cnt_ff : bucket_ff;
   assign bkt_wdata = cmd.clr_step ? '0 : {1'b1, used_ff[NW-1:0]};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         key_ff  <= req_key;
      end
      q_ff  <= KEY_W'(prod >> RSH);
      qb_ff <= q_ff * BC_K;
      if (cmd.bkt_rd) begin
         bucket_ff <= bucket_in;
         bkt_rd_ff <= bucket_mem[bucket_in];
      end
      if (cmd.clr_step || cmd.insert) begin
         bucket_mem[bkt_waddr] <= bkt_wdata;
      end
      if (cmd.node_rd_head || cmd.node_rd_next) begin
         node_rd_ff <= node_mem[node_addr];
      end
      if (cmd.insert) begin
         node_mem[used_ff[NW-1:0]] <= {bkt_rd_ff[NW], bkt_rd_ff[NW-1:0], key_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         used_ff    <= '0;
      end else begin
         if (cmd.clr_step) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (cmd.insert) begin
            used_ff <= used_ff + 1'b1;
         end
      end
   end

   assign sts.clr_last   = (clr_cnt_ff == BC_LAST);
   assign sts.mode       = mode_ff;
   assign sts.bkt_valid  = bkt_rd_ff[NW];
   assign sts.key_match  = (node_rd_ff[KEY_W-1:0] == key_ff);
   assign sts.next_valid = node_rd_ff[KEY_W+NW];
   assign sts.pool_full  = (used_ff == NC_U);

endmodule

>>> src/chk_ctrl.sv
// Controller: sequences hash, bucket read, chain walk, insert and response.
module chk_ctrl import chk_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output dp_cmd_type          cmd,
   input  dp_sts_type          sts
);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_HASH1, S_HASH2, S_HASH3, S_BCHK, S_WALK, S_RESP
   } state_type;

   state_type           state_ff, state_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      cmd           = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_HASH1;
            end
         end
         S_HASH1: state_in = S_HASH2;
         S_HASH2: state_in = S_HASH3;
         S_HASH3: begin
            cmd.bkt_rd = 1'b1;
            state_in   = S_BCHK;
         end
         S_BCHK: begin
            state_in = S_RESP;
            if (sts.mode == MODE_INSERT) begin
               cmd.insert = !sts.pool_full;
               status_in  = sts.pool_full ? ST_FULL : ST_INSERTED;
            end else if (!sts.bkt_valid) begin
               if (sts.mode == MODE_INSERT_NEW) begin
                  cmd.insert = !sts.pool_full;
                  status_in  = sts.pool_full ? ST_FULL : ST_INSERTED;
               end else begin
                  status_in = ST_NOT_FOUND;
               end
            end else begin
               cmd.node_rd_head = 1'b1;
               state_in         = S_WALK;
            end
         end
         S_WALK: begin
            if (sts.key_match) begin
               status_in = (sts.mode == MODE_INSERT_NEW) ? ST_PRESENT : ST_FOUND;
               state_in  = S_RESP;
            end else if (sts.next_valid) begin
               cmd.node_rd_next = 1'b1;
            end else begin
               state_in = S_RESP;
               if (sts.mode == MODE_INSERT_NEW) begin
                  cmd.insert = !sts.pool_full;
                  status_in  = sts.pool_full ? ST_FULL : ST_INSERTED;
               end else begin
                  status_in = ST_NOT_FOUND;
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

>>> verif/chained_hash_key_set_tb.sv
// Self-checking testbench for the chained hash key set: queued stimulus, scoreboard on status.
`timescale 1ns / 100ps

module chained_hash_key_set_tb;
   import chk_pkg::*;

   localparam int BUCKETS    = BUCKET_COUNT_DEFAULT;
   localparam int NODES      = NODE_COUNT_DEFAULT;
   localparam int HOLD_AT    = 120;
   localparam int LONG_HOLD  = 300;
   localparam int RAND_WORDS = 500;
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0]  key;
   } word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [MODE_W-1:0]   req_mode = '0;
   logic [KEY_W-1:0]    req_key = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;

   word_type            pending_words[$];
   logic [STATUS_W-1:0] status_due[$];
   logic [KEY_W-1:0]    stored_keys[$];
   word_type            next_word;
   bit                  req_taken;
   bit                  idle_en = 1'b1;
   bit                  hold_done;
   int                  req_gap;
   int                  stall_left;
   int                  hold_left;
   int                  words_in;
   int                  err_count;

   // mirror of the key set
   bit              set_bkt_valid [BUCKETS];
   bit [12:0]       set_bkt_head  [BUCKETS];
   bit [KEY_W-1:0]  set_node_key  [NODES];
   bit [12:0]       set_node_next [NODES];
   bit              set_node_more [NODES];
   int              set_nodes_used;

   chained_hash_key_set #(
      .BUCKET_COUNT(BUCKETS),
      .NODE_COUNT  (NODES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .req_key   (req_key),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_status(rsp_status)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit chain_holds(int bkt, logic [KEY_W-1:0] key);
      int cur;
      int steps;
      bit live;
      if (!set_bkt_valid[bkt]) return 1'b0;
      cur = int'(set_bkt_head[bkt]);
      live = 1'b1;
      steps = 0;
      while (live && steps < set_nodes_used) begin
         if (set_node_key[cur] == key) return 1'b1;
         live = set_node_more[cur];
         cur = int'(set_node_next[cur]);
         steps++;
      end
      return 1'b0;
   endfunction

   function automatic logic [STATUS_W-1:0] node_push(int bkt, logic [KEY_W-1:0] key);
      int n;
      if (set_nodes_used >= NODES) return ST_FULL;
      n = set_nodes_used;
      set_node_key[n] = key;
      set_node_next[n] = set_bkt_head[bkt];
      set_node_more[n] = set_bkt_valid[bkt];
      set_bkt_head[bkt] = 13'(n);
      set_bkt_valid[bkt] = 1'b1;
      set_nodes_used = n + 1;
      return ST_INSERTED;
   endfunction

   function automatic logic [STATUS_W-1:0] hash_set_apply(logic [MODE_W-1:0] mode,
                                                          logic [KEY_W-1:0] key);
      int bkt;
      bkt = int'(key % BUCKETS);
      if (mode == MODE_INSERT) return node_push(bkt, key);
      if (mode == MODE_INSERT_NEW) return chain_holds(bkt, key) ? ST_PRESENT : node_push(bkt, key);
      return chain_holds(bkt, key) ? ST_FOUND : ST_NOT_FOUND;
   endfunction

   // accept side of the driver
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         status_due.push_back(hash_set_apply(req_mode, req_key));
         req_taken = 1'b1;
         words_in++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_valid && idle_en && $urandom_range(0, 3) == 0)
            req_gap = $urandom_range(1, 19);
         req_taken = 1'b0;
         if (idle_en && req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            next_word = pending_words.pop_front();
            req_valid <= 1'b1;
            req_mode <= next_word.mode;
            req_key <= next_word.key;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && !hold_done && words_in >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (idle_en && stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 18);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (status_due.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual status %0d", $time, rsp_status);
            err_count++;
         end else if (rsp_status !== status_due[0]) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, status_due[0], rsp_status);
            err_count++;
            void'(status_due.pop_front());
         end else begin
            void'(status_due.pop_front());
         end
      end
   end

   task automatic add_word(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key);
      word_type w;
      w.mode = mode;
      w.key = key;
      pending_words.push_back(w);
      if (mode == MODE_INSERT || mode == MODE_INSERT_NEW) stored_keys.push_back(key);
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      bit [31:0] bits;
      bit [9:0]  hot;
      bits = $urandom();
      if (stored_keys.size() > 0 && $urandom_range(0, 1) == 0)
         return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      case ($urandom_range(0, 3))
         0: return bits[30:0];
         1, 2: begin
            hot = 10'($urandom_range(0, 7) * 131);
            return {bits[30:10], hot};
         end
         default: return KEY_W'($urandom_range(0, 4095));
      endcase
   endfunction

   task automatic queue_random_words(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 3)      add_word(MODE_LOOKUP, pick_key());
         else if (pick < 6) add_word(MODE_INSERT, pick_key());
         else if (pick < 9) add_word(MODE_INSERT_NEW, pick_key());
         else               add_word(MODE_SPARE, pick_key());
      end
   endtask

   // checked just after the falling edge, once the driver has settled
   task automatic wait_drained();
      do begin
         @(negedge clock);
         #1;
      end while (pending_words.size() != 0 || status_due.size() != 0 || req_valid);
      @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, extremes, duplicates, collisions
      add_word(MODE_LOOKUP, 31'd0);
      add_word(MODE_LOOKUP, 31'h7FFF_FFFF);
      add_word(MODE_SPARE, 31'd5);
      add_word(MODE_INSERT_NEW, 31'd0);
      add_word(MODE_LOOKUP, 31'd0);
      add_word(MODE_INSERT_NEW, 31'd0);
      add_word(MODE_INSERT, 31'd0);
      add_word(MODE_LOOKUP, 31'd0);
      add_word(MODE_INSERT, 31'h7FFF_FFFF);
      add_word(MODE_LOOKUP, 31'h7FFF_FFFF);
      add_word(MODE_SPARE, 31'h7FFF_FFFF);
      add_word(MODE_INSERT_NEW, 31'd1024);
      add_word(MODE_INSERT_NEW, 31'd2048);
      add_word(MODE_LOOKUP, 31'd1024);
      add_word(MODE_LOOKUP, 31'd3072);
      add_word(MODE_INSERT_NEW, 31'd0);
      add_word(MODE_INSERT, 31'h2AAA_AAAA);
      add_word(MODE_INSERT, 31'h5555_5555);
      add_word(MODE_LOOKUP, 31'h2AAA_AAAA);
      add_word(MODE_SPARE, 31'h5555_5555);
      add_word(MODE_LOOKUP, 31'h4000_0000);
      wait_drained();

      queue_random_words(RAND_WORDS / 2);
      wait_drained();
      queue_random_words(RAND_WORDS - RAND_WORDS / 2);
      wait_drained();

      // back to back to the end
      idle_en = 1'b0;
      add_word(MODE_INSERT, 31'd0);
      add_word(MODE_INSERT_NEW, 31'd0);
      add_word(MODE_INSERT_NEW, 31'h7FFF_FFFE);
      queue_random_words(30);
      wait_drained();

      repeat (40) @(posedge clock);
      if (status_due.size() != 0) begin
         $display("%0t: missing words, expected %0d more, actual none",
                  $time, status_due.size());
         err_count++;
      end
      if (err_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #5000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
